@@ rtl/bearing_pursuit_steering_top_assert.svh @@
// Assertion macros shared by the steering block modules.
`ifndef BEARING_PURSUIT_STEERING_TOP_ASSERT_SVH
`define BEARING_PURSUIT_STEERING_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bps assertion failed");
`define BPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bps assertion failed");
`else
`define BPS_ASSERT_NOW(lbl, ante, cons)
`define BPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/bps_pkg.sv @@
// Types, constants and the arctangent table of the steering block.
package bps_pkg;

    localparam logic [1:0] MODE_POSE   = 2'd0;
    localparam logic [1:0] MODE_TARGET = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic REG_ALIGN = 1'b0;
    localparam logic REG_SPIN  = 1'b1;

    localparam logic [13:0] ALIGN_RESET = 14'd1338;
    localparam logic [14:0] SPIN_RESET  = 15'd256;

    // Product steps of the quaternion multiply sequence.
    localparam logic [2:0] MUL_WZ = 3'd0;
    localparam logic [2:0] MUL_XY = 3'd1;
    localparam logic [2:0] MUL_WW = 3'd2;
    localparam logic [2:0] MUL_XX = 3'd3;
    localparam logic [2:0] MUL_YY = 3'd4;
    localparam logic [2:0] MUL_ZZ = 3'd5;

    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

    localparam logic signed [1:0] TURN_NEG  = 2'sb11;
    localparam logic signed [1:0] TURN_NONE = 2'sb00;
    localparam logic signed [1:0] TURN_POS  = 2'sb01;

    localparam int CIN_W  = 34;
    localparam int CORD_W = 44;
    localparam int ACC_W  = 20;
    localparam int ATAN_N = 24;

    // Normalization targets: coarse steps of eight bits below 2^32, single bits up to 2^40.
    localparam logic signed [CORD_W-1:0] LIM_COARSE = 44'sh001_0000_0000;
    localparam logic signed [CORD_W-1:0] LIM_FINE   = 44'sh100_0000_0000;

    typedef struct packed {
        logic done;
        logic zero;
    } t_cordic_sts;

    // atan(2^-i) in radians with 16 fraction bits.
    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/bps_in_if.sv @@
// Command channel: mode, position, quaternion and spin rate.
interface bps_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] spin_rate_in;

    modport source (
        output valid, mode, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z, spin_rate_in,
        input  ready
    );
    modport sink (
        input  valid, mode, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z, spin_rate_in,
        output ready
    );
endinterface

@@ rtl/bps_out_if.sv @@
// Result channel: turn command, drive command and heading error.
interface bps_out_if;
    logic               valid;
    logic               ready;
    logic signed [1:0]  turn_cmd;
    logic               drive_cmd;
    logic signed [14:0] angle_error;

    modport source (
        output valid, turn_cmd, drive_cmd, angle_error,
        input  ready
    );
    modport sink (
        input  valid, turn_cmd, drive_cmd, angle_error,
        output ready
    );
endinterface

@@ rtl/bearing_pursuit_steering_top.sv @@
// Top level of the bang-bang heading pursuit steering block.
//
//   channel   direction  handshake               carries
//   i_cmd     in         valid/ready             mode, position, quaternion, spin rate
//   o_res     out        valid/ready             turn, drive, heading error
//   apb       in/out     psel/penable/pwrite     align threshold, spin limit
//
// Target updates and unused modes leave the block idle. A control tick runs the CORDIC unit
// on the target offset; the unit stops after its normalize pass when the target sits on the
// robot; a pose update first forms the six products through the one 16x16 multiplier. The
// normalize pass of the shared CORDIC unit makes run lengths vary, and a tick also waits
// while the output register is still full. i_cmd.ready is low while an item is in work.
// A finished result waits in the output register while new items are taken. Reset is
// synchronous and restores the state, settings, positions, heading, spin and output valid.
`include "bearing_pursuit_steering_top_assert.svh"

module bearing_pursuit_steering_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bps_in_if.sink      i_cmd,
    bps_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_KICK  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_ANGLE = 3'd4;
    localparam logic [2:0] S_ERR   = 3'd5;
    localparam logic [2:0] S_RES   = 3'd6;

    logic [2:0]          r_state;
    logic [13:0]         r_align;
    logic [14:0]         r_spin_lim;
    logic signed [31:0]  r_robot_x;
    logic signed [31:0]  r_robot_y;
    logic signed [31:0]  r_target_x;
    logic signed [31:0]  r_target_y;
    logic [14:0]         r_heading;
    logic signed [15:0]  r_spin;
    logic signed [15:0]  r_qw;
    logic signed [15:0]  r_qx;
    logic signed [15:0]  r_qy;
    logic signed [15:0]  r_qz;
    logic                r_tick;
    logic [2:0]          r_k;
    logic signed [33:0]  r_num;
    logic signed [32:0]  r_den;
    logic [14:0]         r_ang;
    logic signed [14:0]  r_err;
    logic                r_out_valid;
    logic signed [1:0]   r_turn;
    logic                r_drive;
    logic signed [14:0]  r_err_out;

    logic                          cmd_acc;
    logic                          tick_acc;
    logic                          pose_acc;
    logic                          res_load;
    logic                          cfg_wr;
    logic                          cord_start;
    logic signed [bps_pkg::CIN_W-1:0] cord_x;
    logic signed [bps_pkg::CIN_W-1:0] cord_y;
    logic signed [15:0]            cord_angle;
    bps_pkg::t_cordic_sts          cord_sts;
    logic signed [32:0]            dx;
    logic signed [32:0]            dy;
    logic signed [15:0]            mul_a;
    logic signed [15:0]            mul_b;
    logic signed [31:0]            prod;
    logic signed [16:0]            err_diff;
    logic [14:0]                   err_mag;
    logic                          spin_below;
    logic                          spin_above;
    logic                          out_free;

    function automatic logic [14:0] wrap_pos(input logic signed [16:0] a);
        logic signed [16:0] t;
        t = a;
        if (t < 0) begin
            t = t + bps_pkg::TWO_PI_Q12;
        end else if (t >= bps_pkg::TWO_PI_Q12) begin
            t = t - bps_pkg::TWO_PI_Q12;
        end
        return t[14:0];
    endfunction

    function automatic logic signed [14:0] wrap_err(input logic signed [16:0] a);
        logic signed [16:0] t;
        t = a;
        if (t < -bps_pkg::PI_Q12) begin
            t = t + bps_pkg::TWO_PI_Q12;
        end else if (t >= bps_pkg::PI_Q12) begin
            t = t - bps_pkg::TWO_PI_Q12;
        end
        return t[14:0];
    endfunction

    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign tick_acc    = cmd_acc && (i_cmd.mode == bps_pkg::MODE_TICK);
    assign pose_acc    = cmd_acc && (i_cmd.mode == bps_pkg::MODE_POSE);
    assign res_load    = (r_state == S_RES) && !r_out_valid;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign cfg_wr      = psel && penable && pwrite;
    assign pready      = 1'b1;
    assign out_free    = !r_out_valid || o_res.ready;

    always_comb begin
        unique case (paddr[2])
            bps_pkg::REG_ALIGN: prdata = {18'd0, r_align};
            bps_pkg::REG_SPIN:  prdata = {17'd0, r_spin_lim};
            default:            prdata = '0;
        endcase
    end

    assign dx = $signed({r_target_x[31], r_target_x}) - $signed({r_robot_x[31], r_robot_x});
    assign dy = $signed({r_target_y[31], r_target_y}) - $signed({r_robot_y[31], r_robot_y});

    // A tick starts the CORDIC pass in its transfer cycle; a pose update after its products.
    assign cord_start = (r_state == S_KICK) || tick_acc;
    assign cord_x     = (r_state == S_KICK) ? bps_pkg::CIN_W'(r_den) : bps_pkg::CIN_W'(dx);
    assign cord_y     = (r_state == S_KICK) ? r_num : bps_pkg::CIN_W'(dy);

    always_comb begin
        case (r_k)
            bps_pkg::MUL_WZ: begin mul_a = r_qw; mul_b = r_qz; end
            bps_pkg::MUL_XY: begin mul_a = r_qx; mul_b = r_qy; end
            bps_pkg::MUL_WW: begin mul_a = r_qw; mul_b = r_qw; end
            bps_pkg::MUL_XX: begin mul_a = r_qx; mul_b = r_qx; end
            bps_pkg::MUL_YY: begin mul_a = r_qy; mul_b = r_qy; end
            default:         begin mul_a = r_qz; mul_b = r_qz; end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign err_diff   = $signed({2'b00, r_ang}) - $signed({2'b00, r_heading});
    assign err_mag    = r_err[14] ? 15'(-r_err) : 15'(r_err);
    assign spin_below = $signed({r_spin[15], r_spin}) < $signed({2'b00, r_spin_lim});
    assign spin_above = $signed({r_spin[15], r_spin}) > -$signed({2'b00, r_spin_lim});

    bps_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_x     (cord_x),
        .i_y     (cord_y),
        .o_angle (cord_angle),
        .o_sts   (cord_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_align     <= bps_pkg::ALIGN_RESET;
            r_spin_lim  <= bps_pkg::SPIN_RESET;
            r_robot_x   <= '0;
            r_robot_y   <= '0;
            r_target_x  <= '0;
            r_target_y  <= '0;
            r_heading   <= '0;
            r_spin      <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    bps_pkg::REG_ALIGN: r_align    <= pwdata[13:0];
                    bps_pkg::REG_SPIN:  r_spin_lim <= pwdata[14:0];
                    default: ;
                endcase
            end

            // In S_RES a new result replaces the one leaving in the same cycle.
            if (r_out_valid && o_res.ready && (r_state != S_RES)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (cmd_acc) begin
                        case (i_cmd.mode)
                            bps_pkg::MODE_POSE: begin
                                r_robot_x <= i_cmd.pos_x;
                                r_robot_y <= i_cmd.pos_y;
                                r_spin    <= i_cmd.spin_rate_in;
                                r_qw      <= i_cmd.quat_w;
                                r_qx      <= i_cmd.quat_x;
                                r_qy      <= i_cmd.quat_y;
                                r_qz      <= i_cmd.quat_z;
                                r_tick    <= 1'b0;
                                r_k       <= bps_pkg::MUL_WZ;
                                r_state   <= S_MUL;
                            end
                            bps_pkg::MODE_TARGET: begin
                                r_target_x <= i_cmd.pos_x;
                                r_target_y <= i_cmd.pos_y;
                            end
                            bps_pkg::MODE_TICK: begin
                                r_tick  <= 1'b1;
                                r_state <= S_WAIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    case (r_k)
                        bps_pkg::MUL_WZ: r_num <= 34'(prod);
                        bps_pkg::MUL_XY: r_num <= (r_num + 34'(prod)) <<< 1;
                        bps_pkg::MUL_WW: r_den <= 33'(prod);
                        bps_pkg::MUL_XX: r_den <= r_den + 33'(prod);
                        default:         r_den <= r_den - 33'(prod);
                    endcase
                    r_k <= r_k + 3'd1;
                    if (r_k == bps_pkg::MUL_ZZ) begin
                        r_state <= S_KICK;
                    end
                end
                S_KICK: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (cord_sts.done) begin
                        r_state <= S_ANGLE;
                    end
                end
                S_ANGLE: begin
                    if (!r_tick) begin
                        r_heading <= wrap_pos(17'(cord_angle) + bps_pkg::HALF_PI_Q12);
                        r_state   <= S_IDLE;
                    end else begin
                        // With the target on the robot the bearing equals the heading.
                        r_ang   <= cord_sts.zero ? r_heading : wrap_pos(17'(cord_angle));
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= wrap_err(err_diff);
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (out_free) begin
                        if ((r_err > 0) && spin_below) begin
                            r_turn <= bps_pkg::TURN_NEG;
                        end else if ((r_err < 0) && spin_above) begin
                            r_turn <= bps_pkg::TURN_POS;
                        end else begin
                            r_turn <= bps_pkg::TURN_NONE;
                        end
                        r_drive     <= (err_mag < {1'b0, r_align});
                        r_err_out   <= r_err;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.turn_cmd    = r_turn;
    assign o_res.drive_cmd   = r_drive;
    assign o_res.angle_error = r_err_out;

    `BPS_ASSERT_NEXT(a_tick_waits, tick_acc, r_state == S_WAIT)
    `BPS_ASSERT_NEXT(a_pose_muls, pose_acc, (r_state == S_MUL) && (r_k == bps_pkg::MUL_WZ))
    `BPS_ASSERT_NOW(a_done_in_wait, cord_sts.done, r_state == S_WAIT)
    `BPS_ASSERT_NEXT(a_res_loads, res_load, r_out_valid && (r_state == S_IDLE))

endmodule

@@ rtl/bps_cordic.sv @@
// Iterative CORDIC vectoring unit: atan2 in Q4.12 with a normalize pass.
`include "bearing_pursuit_steering_top_assert.svh"

module bps_cordic #(
    parameter int STEPS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [bps_pkg::CIN_W-1:0] i_x,
    input  logic signed [bps_pkg::CIN_W-1:0] i_y,
    output logic signed [15:0]              o_angle,
    output bps_pkg::t_cordic_sts            o_sts
);

    localparam int EFF = (STEPS > bps_pkg::ATAN_N) ? bps_pkg::ATAN_N : STEPS;
    localparam logic [4:0] LAST = 5'(EFF - 1);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_NORM  = 2'd1;
    localparam logic [1:0] C_ITER  = 2'd2;
    localparam logic [1:0] C_ROUND = 2'd3;

    logic [1:0]                          r_state;
    logic signed [bps_pkg::CORD_W-1:0]   r_x;
    logic signed [bps_pkg::CORD_W-1:0]   r_y;
    logic signed [bps_pkg::ACC_W-1:0]    r_acc;
    logic [4:0]                          r_i;
    logic                                r_done;
    logic                                r_zero;
    logic signed [15:0]                  r_angle;

    logic                                both_zero;
    logic                                coarse_ok;
    logic                                fine_ok;
    logic signed [bps_pkg::CORD_W-1:0]   xs;
    logic signed [bps_pkg::CORD_W-1:0]   ys;
    logic signed [bps_pkg::ACC_W-1:0]    step_ang;
    logic signed [bps_pkg::ACC_W-1:0]    round_sum;

    assign both_zero = (r_x == '0) && (r_y == '0);
    assign coarse_ok = (r_x < bps_pkg::LIM_COARSE) && (r_x > -bps_pkg::LIM_COARSE) &&
                       (r_y < bps_pkg::LIM_COARSE) && (r_y > -bps_pkg::LIM_COARSE);
    assign fine_ok   = (r_x < bps_pkg::LIM_FINE) && (r_x > -bps_pkg::LIM_FINE) &&
                       (r_y < bps_pkg::LIM_FINE) && (r_y > -bps_pkg::LIM_FINE);
    assign xs        = r_x >>> r_i;
    assign ys        = r_y >>> r_i;
    assign step_ang  = $signed({4'b0000, bps_pkg::atan_q16(r_i)});
    assign round_sum = r_acc + 20'sd8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x     <= bps_pkg::CORD_W'(i_x);
                        r_y     <= bps_pkg::CORD_W'(i_y);
                        r_zero  <= 1'b0;
                        r_state <= C_NORM;
                    end
                end
                C_NORM: begin
                    if (both_zero) begin
                        r_zero  <= 1'b1;
                        r_angle <= '0;
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else if (coarse_ok) begin
                        r_x <= r_x <<< 8;
                        r_y <= r_y <<< 8;
                    end else if (fine_ok) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        // Fold the left half plane onto the right one before iterating.
                        if (r_x < 0) begin
                            if (r_y >= 0) begin
                                r_x   <= r_y;
                                r_y   <= -r_x;
                                r_acc <= bps_pkg::HALF_PI_Q16;
                            end else begin
                                r_x   <= -r_y;
                                r_y   <= r_x;
                                r_acc <= -bps_pkg::HALF_PI_Q16;
                            end
                        end else begin
                            r_acc <= '0;
                        end
                        r_i     <= '0;
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (r_y > 0) begin
                        r_x   <= r_x + ys;
                        r_y   <= r_y - xs;
                        r_acc <= r_acc + step_ang;
                    end else begin
                        r_x   <= r_x - ys;
                        r_y   <= r_y + xs;
                        r_acc <= r_acc - step_ang;
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == LAST) begin
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    r_angle <= round_sum[bps_pkg::ACC_W-1:4];
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_angle   = r_angle;
    assign o_sts.done = r_done;
    assign o_sts.zero = r_zero;

    `BPS_ASSERT_NOW(a_start_idle, i_start, r_state == C_IDLE)
    `BPS_ASSERT_NOW(a_done_idle, r_done, r_state == C_IDLE)
    `BPS_ASSERT_NOW(a_x_right_half, r_state == C_ITER, !r_x[bps_pkg::CORD_W-1])

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the bang-bang heading pursuit steering block.
module tb;

    localparam int STEPS = 16;
    localparam int BLOCK_LATENCY = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 305;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam longint NORM_LIMIT = longint'(1) << 40;
    localparam longint ATAN_Q16 [24] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] spin_rate_in;
    } t_steer_cmd;

    typedef struct {
        logic signed [1:0]  turn;
        logic               drive;
        logic signed [14:0] err_q12;
    } t_steer_res;

    class steering_scoreboard;
        logic [13:0]        align_thr;
        logic [14:0]        spin_lim;
        logic signed [31:0] robot_x, robot_y, target_x, target_y;
        int                 heading;
        logic signed [15:0] spin_rate;
        t_steer_res         pending_steers[$];
        int                 errors;

        function new();
            align_thr = bps_pkg::ALIGN_RESET;
            spin_lim = bps_pkg::SPIN_RESET;
            robot_x = 0;
            robot_y = 0;
            target_x = 0;
            target_y = 0;
            heading = 0;
            spin_rate = 0;
            errors = 0;
        endfunction

        // Vectoring CORDIC: angle of (x, y) in Q4.12, zero for a zero vector.
        function int vector_angle(input longint y_in, input longint x_in);
            longint xv, yv, t, xs, ys, acc;
            int i;
            xv = x_in;
            yv = y_in;
            acc = 0;
            if (xv == 0 && yv == 0) return 0;
            while (((xv < 0) ? -xv : xv) < NORM_LIMIT && ((yv < 0) ? -yv : yv) < NORM_LIMIT) begin
                xv = xv * 2;
                yv = yv * 2;
            end
            // Vectors in the left half plane are turned by a quarter first.
            if (xv < 0) begin
                t = xv;
                if (yv >= 0) begin
                    xv = yv;
                    yv = -t;
                    acc = longint'(bps_pkg::HALF_PI_Q16);
                end else begin
                    xv = -yv;
                    yv = t;
                    acc = -longint'(bps_pkg::HALF_PI_Q16);
                end
            end
            for (i = 0; i < STEPS && i < 24; i++) begin
                xs = xv >>> i;
                ys = yv >>> i;
                if (yv > 0) begin
                    xv = xv + ys;
                    yv = yv - xs;
                    acc = acc + ATAN_Q16[i];
                end else begin
                    xv = xv - ys;
                    yv = yv + xs;
                    acc = acc - ATAN_Q16[i];
                end
            end
            return int'((acc + 8) >>> 4);
        endfunction

        function int wrap_heading(input int a);
            if (a < 0) a = a + int'(bps_pkg::TWO_PI_Q12);
            if (a >= int'(bps_pkg::TWO_PI_Q12)) a = a - int'(bps_pkg::TWO_PI_Q12);
            return a;
        endfunction

        function void note_command(input t_steer_cmd c);
            longint w, x, y, z, num, den, dx, dy;
            int bearing, err, spin, lim, abs_err;
            t_steer_res want;
            case (c.mode)
                bps_pkg::MODE_POSE: begin
                    w = c.quat_w;
                    x = c.quat_x;
                    y = c.quat_y;
                    z = c.quat_z;
                    num = 2 * (w * z + x * y);
                    den = w * w + x * x - y * y - z * z;
                    robot_x = c.pos_x;
                    robot_y = c.pos_y;
                    spin_rate = c.spin_rate_in;
                    heading = wrap_heading(vector_angle(num, den) +
                                           int'(bps_pkg::HALF_PI_Q12));
                end
                bps_pkg::MODE_TARGET: begin
                    target_x = c.pos_x;
                    target_y = c.pos_y;
                end
                bps_pkg::MODE_TICK: begin
                    dx = longint'(target_x) - longint'(robot_x);
                    dy = longint'(target_y) - longint'(robot_y);
                    if (dx == 0 && dy == 0) bearing = heading;
                    else bearing = wrap_heading(vector_angle(dy, dx));
                    err = bearing - heading;
                    if (err < -int'(bps_pkg::PI_Q12)) err = err + int'(bps_pkg::TWO_PI_Q12);
                    if (err >= int'(bps_pkg::PI_Q12)) err = err - int'(bps_pkg::TWO_PI_Q12);
                    spin = spin_rate;
                    lim = int'(spin_lim);
                    if (err > 0 && spin < lim) want.turn = bps_pkg::TURN_NEG;
                    else if (err < 0 && spin > -lim) want.turn = bps_pkg::TURN_POS;
                    else want.turn = bps_pkg::TURN_NONE;
                    abs_err = (err < 0) ? -err : err;
                    want.drive = (abs_err < int'(align_thr));
                    want.err_q12 = 15'(err);
                    pending_steers.push_back(want);
                end
                default: ;
            endcase
        endfunction

        function void check_result(input logic signed [1:0] turn, input logic drive,
                                   input logic signed [14:0] err_q12);
            t_steer_res want;
            if (pending_steers.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: turn %0d drive %0d error %0d",
                             turn, drive, err_q12);
                return;
            end
            want = pending_steers.pop_front();
            if (want.turn !== turn || want.drive !== drive || want.err_q12 !== err_q12) begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: expected turn %0d drive %0d error %0d, got %0d %0d %0d",
                             want.turn, want.drive, want.err_q12, turn, drive, err_q12);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    steering_scoreboard sb = new();

    bps_in_if  cmd_ch();
    bps_out_if res_ch();

    bearing_pursuit_steering_top #(
        .CORDIC_STEPS(STEPS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: checks each transfer, then picks the next ready value.
    // A new hold request keeps ready low for a long stretch so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.turn_cmd, res_ch.drive_cmd, res_ch.angle_error);
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic t_steer_cmd make_cmd(input logic [1:0] mode,
                                            input logic signed [31:0] px,
                                            input logic signed [31:0] py,
                                            input logic signed [15:0] w,
                                            input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            input logic signed [15:0] z,
                                            input logic signed [15:0] spin);
        t_steer_cmd c;
        c.mode = mode;
        c.pos_x = px;
        c.pos_y = py;
        c.quat_w = w;
        c.quat_x = x;
        c.quat_y = y;
        c.quat_z = z;
        c.spin_rate_in = spin;
        return c;
    endfunction

    function automatic logic signed [31:0] random_coord(input logic signed [31:0] near);
        int pick;
        pick = $urandom_range(9);
        if (pick < 5) return 32'(int'($urandom_range(2097152)) - 1048576);
        if (pick < 8) return $urandom();
        if (pick < 9) return near + 32'(int'($urandom_range(2)) - 1);
        case ($urandom_range(3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic signed [15:0] random_quat_part(input int style);
        if (style < 14) return 16'(int'($urandom_range(32768)) - 16384);
        if (style < 17) return 16'($urandom());
        return 16'sh0;
    endfunction

    // Mostly pose, target and tick commands in random order, with a few unused modes.
    function automatic t_steer_cmd random_command();
        t_steer_cmd c;
        int pick, style, spin;
        logic signed [31:0] near_x, near_y;
        pick = $urandom_range(99);
        if (pick < 30) c.mode = bps_pkg::MODE_POSE;
        else if (pick < 55) c.mode = bps_pkg::MODE_TARGET;
        else if (pick < 95) c.mode = bps_pkg::MODE_TICK;
        else c.mode = MODE_UNUSED;
        // Copying the other point now and then gives a zero offset on the next tick.
        if (c.mode == bps_pkg::MODE_POSE) begin
            near_x = sb.target_x;
            near_y = sb.target_y;
        end else begin
            near_x = sb.robot_x;
            near_y = sb.robot_y;
        end
        if ($urandom_range(6) == 0) begin
            c.pos_x = near_x;
            c.pos_y = near_y;
        end else begin
            c.pos_x = random_coord(near_x);
            c.pos_y = random_coord(near_y);
        end
        style = $urandom_range(19);
        c.quat_w = random_quat_part(style);
        c.quat_x = random_quat_part(style);
        c.quat_y = random_quat_part(style);
        c.quat_z = random_quat_part(style);
        if (style == 19) begin
            pick = $urandom_range(7);
            case (pick % 4)
                0:       c.quat_w = (pick < 4) ? 16'sd16384 : -16'sd16384;
                1:       c.quat_x = (pick < 4) ? 16'sd16384 : -16'sd16384;
                2:       c.quat_y = (pick < 4) ? 16'sd16384 : -16'sd16384;
                default: c.quat_z = (pick < 4) ? 16'sd16384 : -16'sd16384;
            endcase
        end
        pick = $urandom_range(9);
        if (pick < 4) begin
            spin = int'(sb.spin_lim) + int'($urandom_range(6)) - 3;
            if ($urandom_range(1) == 1) spin = -spin;
            c.spin_rate_in = 16'(spin);
        end else if (pick < 8) begin
            c.spin_rate_in = 16'(int'($urandom_range(1024)) - 512);
        end else begin
            c.spin_rate_in = 16'($urandom());
        end
        return c;
    endfunction

    task automatic send_item(input t_steer_cmd c);
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode <= c.mode;
        cmd_ch.pos_x <= c.pos_x;
        cmd_ch.pos_y <= c.pos_y;
        cmd_ch.quat_w <= c.quat_w;
        cmd_ch.quat_x <= c.quat_x;
        cmd_ch.quat_y <= c.quat_y;
        cmd_ch.quat_z <= c.quat_z;
        cmd_ch.spin_rate_in <= c.spin_rate_in;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(c);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pose and target updates give no result, so allow for one still in work.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (sb.pending_steers.size() != 0) @(posedge i_clk);
        repeat (BLOCK_LATENCY) @(posedge i_clk);
    endtask

    task automatic set_steering(input int align, input int spin);
        wait_idle();
        write_reg({bps_pkg::REG_ALIGN, 2'b00}, align);
        write_reg({bps_pkg::REG_SPIN, 2'b00}, spin);
        sb.align_thr = 14'(align);
        sb.spin_lim = 15'(spin);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_item(random_command());
    endtask

    task automatic run_directed();
        send_item(make_cmd(bps_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(MODE_UNUSED, -1, -1, -1, -1, -1, -1, -1));
        // Identity orientation points the robot along +y.
        send_item(make_cmd(bps_pkg::MODE_POSE, 0, 0, 16384, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_TARGET, 65536, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_TARGET, 0, 65536, 0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_TARGET, -65536, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        // Spin exactly at the limit blocks the turn in either direction.
        send_item(make_cmd(bps_pkg::MODE_POSE, 0, 0, 16384, 0, 0, 0, 256));
        send_item(make_cmd(bps_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_POSE, 0, 0, 0, 0, 0, 16384, -256));
        send_item(make_cmd(bps_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_POSE, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0,
                           16'sh8000));
        send_item(make_cmd(bps_pkg::MODE_TARGET, 32'sh7fff_ffff, 32'sh7fff_ffff,
                           0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_POSE, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'sh8000,
                           16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff));
        send_item(make_cmd(bps_pkg::MODE_TARGET, 32'sh8000_0000, 32'sh8000_0000,
                           0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_POSE, 32'sh8000_0000, 32'sh8000_0000, 16384, 16384,
                           -16384, -16384, 100));
        send_item(make_cmd(bps_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(bps_pkg::MODE_POSE, 0, 0, -16384, 0, 0, 16384, 0));
        send_item(make_cmd(bps_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
    endtask

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.mode <= bps_pkg::MODE_POSE;
        cmd_ch.pos_x <= '0;
        cmd_ch.pos_y <= '0;
        cmd_ch.quat_w <= '0;
        cmd_ch.quat_x <= '0;
        cmd_ch.quat_y <= '0;
        cmd_ch.quat_z <= '0;
        cmd_ch.spin_rate_in <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_steering(bps_pkg::ALIGN_RESET, bps_pkg::SPIN_RESET);
        run_directed();

        set_steering(0, 0);
        run_random(PHASE_ITEMS);

        set_steering(12867, 32767);
        idle_pct = 66;
        run_random(PHASE_ITEMS);

        set_steering($urandom_range(12867), $urandom_range(32767));
        idle_pct = 0;
        stall_pct = 66;
        run_random(PHASE_ITEMS);

        set_steering(bps_pkg::ALIGN_RESET, bps_pkg::SPIN_RESET);
        idle_pct = 38;
        stall_pct = 38;
        run_random(PHASE_ITEMS);

        // Long receiver hold while commands keep coming.
        set_steering($urandom_range(12867), $urandom_range(2048));
        idle_pct = 0;
        stall_pct = 0;
        hold_seq <= hold_seq + 1;
        run_random(PHASE_ITEMS);

        wait_idle();
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/bps_pkg.sv
rtl/bps_in_if.sv
rtl/bps_out_if.sv
rtl/bps_cordic.sv
rtl/bearing_pursuit_steering_top.sv
tb/tb.sv
